// File: design/chg_pkg.sv
// shared types and defaults for the convex hull block
// used by chg_dp, chg_ctrl and convex_hull_graham_scan; depends on nothing
`default_nettype none
package chg_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic wr;
    logic ld_a;
    logic ld_b;
    logic ld_c;
  } dp_cmd_t;

  // results of the geometry unit, for slots a, b and c
  typedef struct packed {
    logic turn_pos;
    logic turn_neg;
    logic farther;
    logic same_reach;
    logic coincident;
    logic lower;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/convex_hull_graham_scan.sv
// convex hull top level: a point without last_point is taken, busy stays low.
// the last point starts the hull: every orientation test is one pass through the
// point memory read port and the two-stage cross product unit; about 2*n*n tests in all.
// one vertex per strobe, receiver cannot stall. sync reset empties the set, no clearing pass.
// depends on chg_pkg, chg_dp and chg_ctrl
`default_nettype none
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = chg_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chg_pkg::COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_z,
  input  wire logic               last_point,
  output logic                    strobe,
  output logic signed [15:0]      hull_x,
  output logic signed [15:0]      hull_z,
  output logic [3:0]              hull_index,
  output logic                    hull_last,
  output logic                    overflow
);

  localparam int IW = $clog2(MAX_POINTS);

  chg_pkg::dp_cmd_t cmd;
  chg_pkg::dp_sts_t sts;
  logic [IW-1:0] wr_addr, rd_addr;

  // sequencer
  chg_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_point (last_point),
    .sts        (sts),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .busy       (busy),
    .strobe     (strobe),
    .hull_index (hull_index),
    .hull_last  (hull_last),
    .overflow   (overflow)
  );

  // geometry datapath
  chg_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .point_x (point_x),
    .point_z (point_z),
    .sts     (sts),
    .hull_x  (hull_x),
    .hull_z  (hull_z)
  );

  // a result transfer only happens during hull computation
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result strobe while idle");

  // the pivot closes the set and frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && hull_last) |=> !busy)
    else $error("block still busy after last vertex");

  // an ordinary point never starts the computation
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last_point) |=> !busy)
    else $error("busy after plain point load");

endmodule
`default_nettype wire

// File: design/chg_dp.sv
// datapath: point memory, three operand slots and the pipelined cross product unit
// depends on chg_pkg
`default_nettype none
module chg_dp #(
  parameter int MAX_POINTS = chg_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chg_pkg::COORD_BITS_DEF,
  localparam int IW = $clog2(MAX_POINTS)
) (
  input  wire logic                  clk,
  input  wire chg_pkg::dp_cmd_t      cmd,
  input  wire logic [IW-1:0]         wr_addr,
  input  wire logic [IW-1:0]         rd_addr,
  input  wire logic signed [15:0]    point_x,
  input  wire logic signed [15:0]    point_z,
  output chg_pkg::dp_sts_t           sts,
  output logic signed [15:0]         hull_x,
  output logic signed [15:0]         hull_z
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int RW = COORD_BITS + 2;
  localparam int EW = 2 * COORD_BITS;

  logic [EW-1:0] mem [MAX_POINTS];
  logic [EW-1:0] mem_q;
  logic signed [COORD_BITS-1:0] mem_x, mem_z;
  logic signed [COORD_BITS-1:0] ax, az, bx, bz, cx, cz;
  logic signed [DW-1:0] dbx, dbz, dcx, dcz;
  logic signed [PW-1:0] lp, rp;
  logic [RW-1:0] rb, rc;

  function automatic logic [RW-1:0] absd(input logic signed [DW-1:0] v);
    absd = RW'($unsigned(v[DW-1] ? -v : v));
  endfunction

  // point store, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= {COORD_BITS'(point_x), COORD_BITS'(point_z)};
    end
    mem_q <= mem[rd_addr];
  end

  assign mem_x = signed'(mem_q[EW-1:COORD_BITS]);
  assign mem_z = signed'(mem_q[COORD_BITS-1:0]);

  // operand slots
  always_ff @(posedge clk) begin
    if (cmd.ld_a) begin
      ax <= mem_x;
      az <= mem_z;
    end
    if (cmd.ld_b) begin
      bx <= mem_x;
      bz <= mem_z;
    end
    if (cmd.ld_c) begin
      cx <= mem_x;
      cz <= mem_z;
    end
  end

  // stage one: differences from slot a
  always_ff @(posedge clk) begin
    dbx <= DW'(bx) - DW'(ax);
    dbz <= DW'(bz) - DW'(az);
    dcx <= DW'(cx) - DW'(ax);
    dcz <= DW'(cz) - DW'(az);
  end

  // stage two: cross product terms and manhattan reach
  always_ff @(posedge clk) begin
    lp <= dbx * dcz;
    rp <= dcx * dbz;
    rb <= absd(dbx) + absd(dbz);
    rc <= absd(dcx) + absd(dcz);
  end

  // status towards the sequencer
  always_comb begin
    sts.turn_pos   = lp > rp;
    sts.turn_neg   = lp < rp;
    sts.farther    = rc > rb;
    sts.same_reach = rc == rb;
    sts.coincident = (bx == cx) && (bz == cz);
    sts.lower      = (cz < az) || ((cz == az) && (cx > ax));
  end

  assign hull_x = 16'(cx);
  assign hull_z = 16'(cz);

endmodule
`default_nettype wire

// File: design/chg_ctrl.sv
// sequencer: load, pivot search, exclusion, angular rank, graham scan, emission
// holds the order and stack index memories; depends on chg_pkg
`default_nettype none
module chg_ctrl #(
  parameter int MAX_POINTS = chg_pkg::MAX_POINTS_DEF,
  localparam int IW = $clog2(MAX_POINTS)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              last_point,
  input  wire chg_pkg::dp_sts_t  sts,
  output chg_pkg::dp_cmd_t       cmd,
  output logic [IW-1:0]          wr_addr,
  output logic [IW-1:0]          rd_addr,
  output logic                   busy,
  output logic                   strobe,
  output logic [3:0]             hull_index,
  output logic                   hull_last,
  output logic                   overflow
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_POINTS);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PV_NEXT  = 5'd1;
  localparam logic [4:0] S_PV_CHK   = 5'd2;
  localparam logic [4:0] S_EX_I     = 5'd3;
  localparam logic [4:0] S_EX_J     = 5'd4;
  localparam logic [4:0] S_EX_CHK   = 5'd5;
  localparam logic [4:0] S_RK_I     = 5'd6;
  localparam logic [4:0] S_RK_J     = 5'd7;
  localparam logic [4:0] S_RK_CHK   = 5'd8;
  localparam logic [4:0] S_SC_START = 5'd9;
  localparam logic [4:0] S_SC_L1    = 5'd10;
  localparam logic [4:0] S_SC_LOOP  = 5'd11;
  localparam logic [4:0] S_SC_LS    = 5'd12;
  localparam logic [4:0] S_SC_TEST  = 5'd13;
  localparam logic [4:0] S_SC_CHK   = 5'd14;
  localparam logic [4:0] S_SC_POPL  = 5'd15;
  localparam logic [4:0] S_OP_RA    = 5'd16;
  localparam logic [4:0] S_OP_RB    = 5'd17;
  localparam logic [4:0] S_OP_RC    = 5'd18;
  localparam logic [4:0] S_OP_LC    = 5'd19;
  localparam logic [4:0] S_OP_W1    = 5'd20;
  localparam logic [4:0] S_OP_W2    = 5'd21;
  localparam logic [4:0] S_EM_R     = 5'd22;
  localparam logic [4:0] S_EM_P     = 5'd23;
  localparam logic [4:0] S_EM_L     = 5'd24;
  localparam logic [4:0] S_EM_O     = 5'd25;

  logic [4:0] state, ret;
  logic [CW-1:0] cnt, ei, ej, k, d, e, si, d_m3, e_m1;
  logic [IW-1:0] piv, rank, op_a, op_b, op_c, t1, t2, cur, tag;
  logic [MAX_POINTS-1:0] excl;
  logic ovf, cpy, accept;

  logic [IW-1:0] seq_mem [MAX_POINTS];
  logic [IW-1:0] stk_mem [MAX_POINTS];
  logic [IW-1:0] seq_q, stk_q, idx;
  logic seq_we, stk_we;
  logic [IW-1:0] seq_wa, seq_wd, seq_ra, stk_wa, stk_wd, stk_ra;

  assign accept = start && (state == S_IDLE);
  assign idx    = cpy ? seq_q : stk_q;
  assign d_m3   = d - CW'(3);
  assign e_m1   = e - CW'(1);

  // index memory ports
  always_comb begin
    seq_we = 1'b0;
    seq_wa = rank + IW'(1);
    seq_wd = ei[IW-1:0];
    seq_ra = si[IW-1:0];
    stk_we = 1'b0;
    stk_wa = d[IW-1:0];
    stk_wd = cur;
    stk_ra = d_m3[IW-1:0];
    unique case (state)
      S_EX_I: begin
        if (ei == cnt) begin
          seq_we = 1'b1;
          seq_wa = '0;
          seq_wd = piv;
        end
      end
      S_RK_J: begin
        seq_we = (ej == cnt);
      end
      S_SC_START: begin
        seq_ra = IW'(1);
        stk_we = (k >= CW'(3));
        stk_wa = '0;
        stk_wd = piv;
      end
      S_SC_L1: begin
        stk_we = 1'b1;
        stk_wa = IW'(1);
        stk_wd = seq_q;
      end
      S_SC_TEST: begin
        stk_we = (d < CW'(2)) && (d < CAP);
      end
      S_SC_CHK: begin
        stk_we = sts.turn_pos && (d < CAP);
      end
      S_EM_R: begin
        seq_ra = e_m1[IW-1:0];
        stk_ra = e_m1[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[seq_wa] <= seq_wd;
    end
    seq_q <= seq_mem[seq_ra];
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  // datapath commands
  always_comb begin
    cmd.wr   = accept && (cnt < CAP);
    cmd.ld_a = (state == S_OP_RB);
    cmd.ld_b = (state == S_OP_RC);
    cmd.ld_c = (state == S_OP_LC) || (state == S_EM_L);
    wr_addr  = cnt[IW-1:0];
    unique case (state)
      S_OP_RB: rd_addr = op_b;
      S_OP_RC: rd_addr = op_c;
      S_EM_P:  rd_addr = idx;
      default: rd_addr = op_a;
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign strobe     = (state == S_EM_O);
  assign hull_index = 4'(tag);
  assign hull_last  = (e == CW'(1));
  assign overflow   = ovf;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
      excl  <= '0;
      cpy   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cnt < CAP) begin
              cnt <= cnt + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last_point) begin
              piv   <= '0;
              ei    <= CW'(1);
              excl  <= '0;
              state <= S_PV_NEXT;
            end
          end
        end
        // pivot: lowest z, then largest x
        S_PV_NEXT: begin
          if (ei >= cnt) begin
            ei    <= '0;
            state <= S_EX_I;
          end else begin
            op_a  <= piv;
            op_b  <= piv;
            op_c  <= ei[IW-1:0];
            ret   <= S_PV_CHK;
            state <= S_OP_RA;
          end
        end
        S_PV_CHK: begin
          if (sts.lower) begin
            piv <= op_c;
          end
          ei    <= ei + CW'(1);
          state <= S_PV_NEXT;
        end
        // drop nearer points collinear with the pivot
        S_EX_I: begin
          if (ei == cnt) begin
            k     <= CW'(1);
            ei    <= '0;
            state <= S_RK_I;
          end else if (ei == CW'(piv)) begin
            ei <= ei + CW'(1);
          end else begin
            ej    <= '0;
            state <= S_EX_J;
          end
        end
        S_EX_J: begin
          if (ej == cnt) begin
            ei    <= ei + CW'(1);
            state <= S_EX_I;
          end else if (ej == CW'(piv) || ej == ei) begin
            ej <= ej + CW'(1);
          end else begin
            op_a  <= piv;
            op_b  <= ei[IW-1:0];
            op_c  <= ej[IW-1:0];
            ret   <= S_EX_CHK;
            state <= S_OP_RA;
          end
        end
        S_EX_CHK: begin
          if (!sts.turn_pos && !sts.turn_neg &&
              (sts.farther || (sts.same_reach && sts.coincident && ej > ei))) begin
            excl[ei[IW-1:0]] <= 1'b1;
            ei    <= ei + CW'(1);
            state <= S_EX_I;
          end else begin
            ej    <= ej + CW'(1);
            state <= S_EX_J;
          end
        end
        // angular rank of each survivor
        S_RK_I: begin
          if (ei == cnt) begin
            state <= S_SC_START;
          end else if (ei == CW'(piv) || excl[ei[IW-1:0]]) begin
            ei <= ei + CW'(1);
          end else begin
            rank  <= '0;
            ej    <= '0;
            state <= S_RK_J;
          end
        end
        S_RK_J: begin
          if (ej == cnt) begin
            k     <= k + CW'(1);
            ei    <= ei + CW'(1);
            state <= S_RK_I;
          end else if (ej == CW'(piv) || ej == ei || excl[ej[IW-1:0]]) begin
            ej <= ej + CW'(1);
          end else begin
            op_a  <= piv;
            op_b  <= ei[IW-1:0];
            op_c  <= ej[IW-1:0];
            ret   <= S_RK_CHK;
            state <= S_OP_RA;
          end
        end
        S_RK_CHK: begin
          if (sts.turn_neg) begin
            rank <= rank + IW'(1);
          end
          ej    <= ej + CW'(1);
          state <= S_RK_J;
        end
        // graham scan, top two entries cached
        S_SC_START: begin
          if (k < CW'(3)) begin
            cpy   <= 1'b1;
            d     <= k;
            e     <= k;
            state <= S_EM_R;
          end else begin
            state <= S_SC_L1;
          end
        end
        S_SC_L1: begin
          t2    <= piv;
          t1    <= seq_q;
          d     <= CW'(2);
          si    <= CW'(2);
          state <= S_SC_LOOP;
        end
        S_SC_LOOP: begin
          if (si == k) begin
            cpy   <= 1'b0;
            e     <= d;
            state <= S_EM_R;
          end else begin
            state <= S_SC_LS;
          end
        end
        S_SC_LS: begin
          cur   <= seq_q;
          state <= S_SC_TEST;
        end
        S_SC_TEST: begin
          if (d < CW'(2)) begin
            if (d < CAP) begin
              t2 <= t1;
              t1 <= cur;
              d  <= d + CW'(1);
            end
            si    <= si + CW'(1);
            state <= S_SC_LOOP;
          end else begin
            op_a  <= t2;
            op_b  <= t1;
            op_c  <= cur;
            ret   <= S_SC_CHK;
            state <= S_OP_RA;
          end
        end
        S_SC_CHK: begin
          if (sts.turn_pos) begin
            if (d < CAP) begin
              t2 <= t1;
              t1 <= cur;
              d  <= d + CW'(1);
            end
            si    <= si + CW'(1);
            state <= S_SC_LOOP;
          end else begin
            d  <= d - CW'(1);
            t1 <= t2;
            if (d >= CW'(3)) begin
              state <= S_SC_POPL;
            end else begin
              state <= S_SC_TEST;
            end
          end
        end
        S_SC_POPL: begin
          t2    <= stk_q;
          state <= S_SC_TEST;
        end
        // operand fetch and cross product wait
        S_OP_RA: state <= S_OP_RB;
        S_OP_RB: state <= S_OP_RC;
        S_OP_RC: state <= S_OP_LC;
        S_OP_LC: state <= S_OP_W1;
        S_OP_W1: state <= S_OP_W2;
        S_OP_W2: state <= ret;
        // emission from stack top down to the pivot
        S_EM_R: state <= S_EM_P;
        S_EM_P: begin
          tag   <= idx;
          state <= S_EM_L;
        end
        S_EM_L: state <= S_EM_O;
        S_EM_O: begin
          e <= e - CW'(1);
          if (e == CW'(1)) begin
            cnt   <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end else begin
            state <= S_EM_R;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
